@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the literal converter.
// Depends on nothing; take in with `include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define ILW_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ilw assertion failed");
// Check that a condition never occurs outside reset.
`define ILW_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ilw forbidden condition seen");
`else
`define ILW_ASSERT(label, clk, rst_n, prop)
`define ILW_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/ilw_pkg.sv @@
// Types, constants and digit helpers for the integer literal converter.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ilw_pkg;

	localparam int CHAR_BITS = 8;
	localparam int WORD_BITS = 32;

	typedef enum logic [1:0] {
		RADIX_NONE = 2'd0,
		RADIX_OCT  = 2'd1,
		RADIX_DEC  = 2'd2,
		RADIX_HEX  = 2'd3
	} radix_t;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_BITS-1:0] CHAR_LOWER_X = 8'h78;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER_X = 8'h58;
	localparam logic [CHAR_BITS-1:0] CASE_OFFSET  = 8'h20;

	localparam logic [WORD_BITS-1:0] DIGIT_BIAS  = 32'd48;
	localparam logic [WORD_BITS-1:0] LETTER_BIAS = 32'd87;
	localparam logic [WORD_BITS-1:0] SIGN_ONLY   = 32'h8000_0000;

	// Largest accumulator that still scales without loss, per radix.
	localparam logic [WORD_BITS-1:0] LIMIT_OCT = (32'h7FFF_FFFF / 32'd8) * 32'd2 + 32'd1;
	localparam logic [WORD_BITS-1:0] LIMIT_DEC = (32'h7FFF_FFFF / 32'd10) * 32'd2 + 32'd1;
	localparam logic [WORD_BITS-1:0] LIMIT_HEX = (32'h7FFF_FFFF / 32'd16) * 32'd2 + 32'd1;

	// Map a character to its digit, unchecked; letters fold to lower case.
	function automatic logic [WORD_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
		logic [CHAR_BITS-1:0] low;
		low = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			return {{(WORD_BITS-CHAR_BITS){1'b0}}, low} - DIGIT_BIAS;
		end
		return {{(WORD_BITS-CHAR_BITS){1'b0}}, low} - LETTER_BIAS;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ilw_if.sv @@
// Valid/ready channels of the literal converter: characters in, words out.
// Depends on ilw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ilw_char_if;
	logic                           valid;
	logic                           ready;
	logic [ilw_pkg::CHAR_BITS-1:0]  char_code;
	logic                           negate;
	logic                           last_char;

	modport source(output valid, char_code, negate, last_char, input ready);
	modport sink(input valid, char_code, negate, last_char, output ready);
endinterface

interface ilw_word_if;
	logic                           valid;
	logic                           ready;
	logic [ilw_pkg::WORD_BITS-1:0]  value;
	logic                           overflowed;
	logic                           sign_warning;

	modport source(output valid, value, overflowed, sign_warning, input ready);
	modport sink(input valid, value, overflowed, sign_warning, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/integer_literal_to_word32.sv @@
// Top level of the integer literal converter: character stream in, 32-bit word out.
// Depends on ilw_pkg, ilw_if.sv (channels) and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Converts an integer literal, sent one character per request on chars with
// last_char marking its final character, into a 32-bit word on words, picking
// the radix from the prefix: "0x"/"0X" hex, a leading '0' octal, otherwise
// decimal. Digits are not checked. On overflow the rest of the literal is
// skipped and value carries the position (from 0) of the offending character
// with overflowed set; a decimal word with bit 31 set, other than 0x80000000,
// sets sign_warning. negate on the final character gives the two's complement
// (0x80000000 is left as is). Throughput is one character per cycle while no final
// character waits for the result register: each character is held in the input
// register, then one constant-radix shift-add with a carry compare updates the
// accumulator. A word is loaded into the result register as its final character
// leaves the input register, when that register is free or being emptied, and
// is held there until taken. Only a final character waits for the result register;
// a stalled result does not hold up the characters of the next literal until
// its own final character arrives.
module integer_literal_to_word32 #(
	parameter int POSITION_BITS = 10
) (
	input  wire          clk,
	input  wire          arst_n,
	ilw_char_if.sink     chars,
	ilw_word_if.source   words
);

	localparam int WB = ilw_pkg::WORD_BITS;
	localparam int CB = ilw_pkg::CHAR_BITS;
	localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_PREFIX = POSITION_BITS'(1);

	// Input register
	logic                   valid_s1;
	logic [CB-1:0]          char_s1;
	logic                   negate_s1;
	logic                   last_s1;

	// Literal state
	logic [POSITION_BITS-1:0] pos_q;
	ilw_pkg::radix_t          radix_q;
	logic [WB-1:0]            acc_q;
	logic                     ovf_q;
	logic [POSITION_BITS-1:0] ovf_pos_q;

	// Result register
	logic                   out_valid_q;
	logic [WB-1:0]          value_q;
	logic                   overflowed_q;
	logic                   warn_q;

	logic                   consume;
	logic                   finish;

	ilw_pkg::radix_t          nxt_radix;
	logic                     take;
	logic [WB-1:0]            digit;
	logic [WB-1:0]            scaled;
	logic [WB-1:0]            limit;
	logic [WB:0]              sum;
	logic                     step_ovf;
	logic [WB-1:0]            nxt_acc;
	logic                     nxt_ovf;
	logic [POSITION_BITS-1:0] nxt_ovf_pos;
	logic [POSITION_BITS-1:0] nxt_pos;
	logic [WB-1:0]            res_value;
	logic                     res_warn;

	// A final character needs room in the result register; others always move on.
	assign consume     = valid_s1 && (!last_s1 || !out_valid_q || words.ready);
	assign finish      = consume && last_s1;
	assign chars.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1   <= chars.char_code;
			negate_s1 <= chars.negate;
			last_s1   <= chars.last_char;
		end
	end

	// One character step: settle the radix from the prefix, then scale and add.
	always_comb begin
		nxt_radix = radix_q;
		take      = 1'b1;
		if (!ovf_q) begin
			unique case (radix_q)
				ilw_pkg::RADIX_NONE: begin
					if (char_s1 == ilw_pkg::CHAR_ZERO) begin
						nxt_radix = ilw_pkg::RADIX_OCT;
						take      = 1'b0;
					end else begin
						nxt_radix = ilw_pkg::RADIX_DEC;
					end
				end
				ilw_pkg::RADIX_OCT: begin
					if (pos_q == POS_PREFIX && (char_s1 == ilw_pkg::CHAR_LOWER_X ||
							char_s1 == ilw_pkg::CHAR_UPPER_X)) begin
						nxt_radix = ilw_pkg::RADIX_HEX;
						take      = 1'b0;
					end
				end
				ilw_pkg::RADIX_DEC, ilw_pkg::RADIX_HEX: begin
				end
			endcase
		end

		digit = ilw_pkg::digit_of(char_s1);
		unique case (nxt_radix)
			ilw_pkg::RADIX_HEX: begin
				scaled = acc_q << 4;
				limit  = ilw_pkg::LIMIT_HEX;
			end
			ilw_pkg::RADIX_OCT: begin
				scaled = acc_q << 3;
				limit  = ilw_pkg::LIMIT_OCT;
			end
			ilw_pkg::RADIX_NONE, ilw_pkg::RADIX_DEC: begin
				scaled = (acc_q << 3) + (acc_q << 1);
				limit  = ilw_pkg::LIMIT_DEC;
			end
		endcase

		// Carry out of the add is the wrap test on the digit.
		sum      = {1'b0, scaled} + {1'b0, digit};
		step_ovf = !ovf_q && take && (acc_q > limit || sum[WB]);

		nxt_acc     = (!ovf_q && take && !step_ovf) ? sum[WB-1:0] : acc_q;
		nxt_ovf     = ovf_q || step_ovf;
		nxt_ovf_pos = step_ovf ? pos_q : ovf_pos_q;
		nxt_pos     = (pos_q == POS_LIMIT) ? pos_q : pos_q + POSITION_BITS'(1);

		res_warn  = nxt_radix == ilw_pkg::RADIX_DEC && nxt_acc[WB-1] &&
			nxt_acc != ilw_pkg::SIGN_ONLY;
		res_value = nxt_acc;
		if (negate_s1 && nxt_acc != ilw_pkg::SIGN_ONLY) begin
			res_value = '0 - nxt_acc;
		end
		if (nxt_ovf) begin
			res_value = {{(WB-POSITION_BITS){1'b0}}, nxt_ovf_pos};
			res_warn  = 1'b0;
		end
	end

	// Advance the literal state; drop back to reset after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			radix_q   <= ilw_pkg::RADIX_NONE;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			ovf_pos_q <= '0;
		end else if (finish) begin
			pos_q     <= '0;
			radix_q   <= ilw_pkg::RADIX_NONE;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			ovf_pos_q <= '0;
		end else if (consume) begin
			pos_q     <= nxt_pos;
			radix_q   <= nxt_radix;
			acc_q     <= nxt_acc;
			ovf_q     <= nxt_ovf;
			ovf_pos_q <= nxt_ovf_pos;
		end
	end

	// Result register: load on a final character, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			value_q      <= res_value;
			overflowed_q <= nxt_ovf;
			warn_q       <= res_warn;
		end
	end

	assign words.valid        = out_valid_q;
	assign words.value        = value_q;
	assign words.overflowed   = overflowed_q;
	assign words.sign_warning = warn_q;

	`ILW_NEVER(a_ovf_no_warn, clk, arst_n, out_valid_q && overflowed_q && warn_q)
	`ILW_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !consume |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
	`ILW_ASSERT(a_state_clears, clk, arst_n, finish |=> pos_q == '0 && radix_q == ilw_pkg::RADIX_NONE && acc_q == '0 && !ovf_q)
	`ILW_ASSERT(a_result_held, clk, arst_n, out_valid_q && !words.ready |=> out_valid_q && $stable(value_q))
	`ILW_NEVER(a_hex_after_prefix, clk, arst_n, radix_q == ilw_pkg::RADIX_HEX && pos_q < POSITION_BITS'(2))

endmodule
`default_nettype wire
